FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the note token parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold on every clock edge out of reset.
`define MNTP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mntp assertion failed");
// Same-cycle implication.
`define MNTP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mntp implication failed");
// Next-cycle implication.
`define MNTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mntp next-cycle implication failed");
`else
`define MNTP_ASSERT(lbl, clk, rstn, prop)
`define MNTP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MNTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/mntp_pkg.sv
// Shared types and constants of the note token parser.
package mntp_pkg;

  // Default parameter values
  localparam int DEF_QUANT_UNITS = 64;
  localparam int DEF_BASE_OCTAVE = 3;

  // Field widths and limits
  localparam int CHAR_W = 8;
  localparam int DV_W   = 10;
  localparam int LEN_W  = 7;
  localparam logic [DV_W-1:0]  DV_MAX  = 10'd1023;
  localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;
  localparam logic signed [3:0] ALT_MAX = 4'sd4;
  localparam logic signed [3:0] ALT_MIN = -4'sd4;
  localparam logic signed [4:0] OCT_MAX = 5'sd15;
  localparam logic signed [4:0] OCT_MIN = -5'sd16;
  localparam logic [3:0] DOTS_MAX = 4'd15;
  localparam logic [2:0] PITCH_REST = 3'd7;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;

  // Grammar position inside a token
  typedef enum logic [2:0] {
    PH_PITCH = 3'd0,
    PH_ACC   = 3'd1,
    PH_OCT   = 3'd2,
    PH_DIG   = 3'd3,
    PH_DOT   = 3'd4
  } phase_t;

  // Accidental letter waiting for its 's'
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_I    = 2'd1,
    PEND_E    = 2'd2
  } pend_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_RUN  = 3'd0,
    ST_EVAL = 3'd1,
    ST_DIV  = 3'd2,
    ST_DOTS = 3'd3,
    ST_FIN  = 3'd4
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_char;
    logic div_start;
    logic div_step;
    logic dot_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err_gram;
    logic dv_zero;
    logic div_done;
    logic dots_done;
  } sts_t;

  // One result word
  typedef struct packed {
    logic              valid_res;
    logic [2:0]        pitch;
    logic signed [3:0] alteration;
    logic signed [4:0] octave;
    logic [LEN_W-1:0]  note_length;
    logic              bad_accidental;
    logic              saturated;
  } res_t;

endpackage

FILE: hw/rtl/mntp_ctrl.sv
// Sequencing controller of the note token parser.
`include "assert_macros.svh"

module mntp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tlast,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output mntp_pkg::cmd_t cmd,
  input  mntp_pkg::sts_t sts
);

  mntp_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mntp_pkg::ST_RUN: begin
        if (in_tvalid && in_tlast) state_nxt = mntp_pkg::ST_EVAL;
      end
      mntp_pkg::ST_EVAL: begin
        if (sts.err_gram || sts.dv_zero) state_nxt = mntp_pkg::ST_FIN;
        else state_nxt = mntp_pkg::ST_DIV;
      end
      mntp_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = mntp_pkg::ST_DOTS;
      end
      mntp_pkg::ST_DOTS: begin
        if (sts.dots_done) state_nxt = mntp_pkg::ST_FIN;
      end
      mntp_pkg::ST_FIN: begin
        if (out_free) state_nxt = mntp_pkg::ST_RUN;
      end
      default: state_nxt = mntp_pkg::ST_RUN;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      mntp_pkg::ST_RUN: begin
        in_tready     = 1'b1;
        cmd.take_char = in_tvalid;
      end
      mntp_pkg::ST_EVAL: begin
        cmd.div_start = !(sts.err_gram || sts.dv_zero);
      end
      mntp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      mntp_pkg::ST_DOTS: begin
        cmd.dot_step = !sts.dots_done;
      end
      mntp_pkg::ST_FIN: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Output word valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mntp_pkg::ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MNTP_ASSERT_IMPL(a_load_into_free_slot, clk, rst_n, cmd.load_out, out_free)
  `MNTP_ASSERT_NEXT(a_load_shows_word, clk, rst_n, cmd.load_out, out_tvalid)
  `MNTP_ASSERT_IMPL(a_eval_after_last, clk, rst_n, state_r == mntp_pkg::ST_EVAL,
                    $past(in_tvalid && in_tready && in_tlast))

endmodule

FILE: hw/rtl/mntp_dp.sv
// Datapath of the note token parser: token state, divider, dot adder, result word.
`include "assert_macros.svh"

module mntp_dp #(
  parameter int QUANT_UNITS = mntp_pkg::DEF_QUANT_UNITS,
  parameter int BASE_OCTAVE = mntp_pkg::DEF_BASE_OCTAVE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mntp_pkg::CHAR_W-1:0]   ch,
  input  mntp_pkg::cmd_t                cmd,
  output mntp_pkg::sts_t                sts,
  output mntp_pkg::res_t                res
);

  localparam int QW    = $clog2(QUANT_UNITS + 1);
  localparam int CW    = (QW > 1) ? $clog2(QW) : 1;
  localparam int ACC_W = QW + 1;
  localparam int EXT_W = (ACC_W > mntp_pkg::LEN_W) ? ACC_W : mntp_pkg::LEN_W;
  localparam int DV_W  = mntp_pkg::DV_W;
  localparam logic [QW-1:0] QV = QW'(QUANT_UNITS);
  localparam logic signed [4:0] OCT_BASE = 5'(BASE_OCTAVE);

  // Token state
  mntp_pkg::phase_t phase_r, phase_nxt;
  mntp_pkg::pend_t  pend_r, pend_nxt;
  logic [2:0]        pitch_r, pitch_nxt;
  logic signed [3:0] alt_r, alt_nxt;
  logic signed [4:0] oct_r, oct_nxt;
  logic [DV_W-1:0]   dv_r, dv_nxt;
  logic [3:0]        dots_r, dots_nxt;
  logic              gram_r, gram_nxt;
  logic              bad_r, bad_nxt;
  logic              sat_r, sat_nxt;
  logic [mntp_pkg::LEN_W-1:0] last_dur_r, last_dur_nxt;

  // Divider and dot adder
  logic [DV_W-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [QW-1:0]    inc_r, inc_nxt;
  logic [DV_W:0]    rem_sh;
  logic [DV_W:0]    rem_sub;
  logic             ge;
  logic [QW-1:0]    quo_step;

  // Character decode helpers
  logic [13:0] dv_prod;
  logic [3:0]  digit;

  // Result assembly
  mntp_pkg::res_t res_r, res_nxt;
  logic [EXT_W-1:0]           acc_ext;
  logic                       clip;
  logic [mntp_pkg::LEN_W-1:0] dur;

  assign digit   = 4'(ch - mntp_pkg::CH_0);
  assign dv_prod = {dv_r, 3'b000} + {3'b000, dv_r, 1'b0} + {10'd0, digit};

  // Restoring divide step: constant dividend, digit value as divisor
  assign rem_sh   = {rem_r, QV[cnt_r]};
  assign ge       = rem_sh >= {1'b0, dv_r};
  assign rem_sub  = rem_sh - {1'b0, dv_r};
  assign quo_step = (quo_r << 1) | QW'(ge);

  assign sts.err_gram  = gram_r;
  assign sts.dv_zero   = (dv_r == '0);
  assign sts.div_done  = (cnt_r == '0);
  assign sts.dots_done = (dots_r == 4'd0) || (inc_r == '0);

  // Token state update per character
  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    pitch_nxt = pitch_r;
    alt_nxt   = alt_r;
    oct_nxt   = oct_r;
    dv_nxt    = dv_r;
    dots_nxt  = dots_r;
    gram_nxt  = gram_r;
    bad_nxt   = bad_r;
    sat_nxt   = sat_r;
    if (cmd.take_char && !gram_r) begin
      if (phase_r == mntp_pkg::PH_PITCH) begin
        if (ch >= mntp_pkg::CH_A && ch <= mntp_pkg::CH_G) begin
          pitch_nxt = 3'(ch - mntp_pkg::CH_A);
          phase_nxt = mntp_pkg::PH_ACC;
        end else if (ch == mntp_pkg::CH_R) begin
          pitch_nxt = mntp_pkg::PITCH_REST;
          phase_nxt = mntp_pkg::PH_ACC;
        end else begin
          gram_nxt = 1'b1;
        end
      end else if (ch == mntp_pkg::CH_I || ch == mntp_pkg::CH_E || ch == mntp_pkg::CH_S) begin
        if (phase_r != mntp_pkg::PH_ACC) begin
          gram_nxt = 1'b1;
        end else if (ch == mntp_pkg::CH_S) begin
          // 's' closes a pending letter
          if (pend_r == mntp_pkg::PEND_I) begin
            if (alt_r == mntp_pkg::ALT_MAX) sat_nxt = 1'b1;
            else alt_nxt = alt_r + 4'sd1;
          end else if (pend_r == mntp_pkg::PEND_E) begin
            if (alt_r == mntp_pkg::ALT_MIN) sat_nxt = 1'b1;
            else alt_nxt = alt_r - 4'sd1;
          end else begin
            bad_nxt = 1'b1;
          end
          pend_nxt = mntp_pkg::PEND_NONE;
        end else begin
          if (pend_r != mntp_pkg::PEND_NONE) bad_nxt = 1'b1;
          pend_nxt = (ch == mntp_pkg::CH_I) ? mntp_pkg::PEND_I : mntp_pkg::PEND_E;
        end
      end else if (ch == mntp_pkg::CH_QUOTE || ch == mntp_pkg::CH_COMMA) begin
        if (phase_r > mntp_pkg::PH_OCT) begin
          gram_nxt = 1'b1;
        end else begin
          if (pend_r != mntp_pkg::PEND_NONE) bad_nxt = 1'b1;
          pend_nxt  = mntp_pkg::PEND_NONE;
          phase_nxt = mntp_pkg::PH_OCT;
          if (ch == mntp_pkg::CH_QUOTE) begin
            if (oct_r == mntp_pkg::OCT_MAX) sat_nxt = 1'b1;
            else oct_nxt = oct_r + 5'sd1;
          end else begin
            if (oct_r == mntp_pkg::OCT_MIN) sat_nxt = 1'b1;
            else oct_nxt = oct_r - 5'sd1;
          end
        end
      end else if (ch >= mntp_pkg::CH_0 && ch <= mntp_pkg::CH_9) begin
        if (phase_r > mntp_pkg::PH_DIG) begin
          gram_nxt = 1'b1;
        end else begin
          if (pend_r != mntp_pkg::PEND_NONE) bad_nxt = 1'b1;
          pend_nxt  = mntp_pkg::PEND_NONE;
          phase_nxt = mntp_pkg::PH_DIG;
          if (dv_prod > 14'(mntp_pkg::DV_MAX)) begin
            dv_nxt  = mntp_pkg::DV_MAX;
            sat_nxt = 1'b1;
          end else begin
            dv_nxt = dv_prod[DV_W-1:0];
          end
        end
      end else if (ch == mntp_pkg::CH_DOT) begin
        if (pend_r != mntp_pkg::PEND_NONE) bad_nxt = 1'b1;
        pend_nxt  = mntp_pkg::PEND_NONE;
        phase_nxt = mntp_pkg::PH_DOT;
        if (dots_r != mntp_pkg::DOTS_MAX) dots_nxt = dots_r + 4'd1;
      end else begin
        gram_nxt = 1'b1;
      end
    end
    // dot loop counts the dots down
    if (cmd.dot_step) dots_nxt = dots_r - 4'd1;
  end

  // Divider and dot adder
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    inc_nxt = inc_r;
    if (cmd.div_start) begin
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = CW'(QW - 1);
    end else if (cmd.div_step) begin
      rem_nxt = ge ? rem_sub[DV_W-1:0] : rem_sh[DV_W-1:0];
      quo_nxt = quo_step;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        acc_nxt = ACC_W'(quo_step);
        inc_nxt = quo_step >> 1;
      end
    end else if (cmd.dot_step) begin
      acc_nxt = acc_r + ACC_W'(inc_r);
      inc_nxt = inc_r >> 1;
    end
  end

  // Result word at token end
  assign acc_ext = EXT_W'(acc_r);
  assign clip    = acc_ext > EXT_W'(mntp_pkg::LEN_MAX);
  always_comb begin
    dur = sts.dv_zero ? last_dur_r
                      : (clip ? mntp_pkg::LEN_MAX : acc_ext[mntp_pkg::LEN_W-1:0]);
    res_nxt      = '0;
    last_dur_nxt = last_dur_r;
    if (!gram_r) begin
      res_nxt.valid_res      = (dur != '0);
      res_nxt.pitch          = pitch_r;
      res_nxt.alteration     = alt_r;
      res_nxt.octave         = oct_r;
      res_nxt.note_length    = dur;
      res_nxt.bad_accidental = bad_r || (pend_r != mntp_pkg::PEND_NONE);
      res_nxt.saturated      = sat_r || (!sts.dv_zero && clip);
      if (cmd.load_out && dur != '0) last_dur_nxt = dur;
    end
  end

  // Control state with reset, cleared again after each token
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      phase_r <= mntp_pkg::PH_PITCH;
      pend_r  <= mntp_pkg::PEND_NONE;
      pitch_r <= '0;
      alt_r   <= '0;
      oct_r   <= OCT_BASE;
      dv_r    <= '0;
      dots_r  <= '0;
      gram_r  <= 1'b0;
      bad_r   <= 1'b0;
      sat_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      pitch_r <= pitch_nxt;
      alt_r   <= alt_nxt;
      oct_r   <= oct_nxt;
      dv_r    <= dv_nxt;
      dots_r  <= dots_nxt;
      gram_r  <= gram_nxt;
      bad_r   <= bad_nxt;
      sat_r   <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dur_r <= '0;
    end else begin
      last_dur_r <= last_dur_nxt;
    end
  end

  // Work registers and result word
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    inc_r <= inc_nxt;
    if (cmd.load_out) res_r <= res_nxt;
  end

  assign res = res_r;

  `MNTP_ASSERT_IMPL(a_no_div_by_zero, clk, rst_n, cmd.div_step, dv_r != '0)
  `MNTP_ASSERT(a_one_command, clk, rst_n, $onehot0(cmd))
  `MNTP_ASSERT_IMPL(a_dot_step_live, clk, rst_n, cmd.dot_step,
                    dots_r != 4'd0 && inc_r != '0)

endmodule

FILE: hw/rtl/music_note_token_parser_unit.sv
// Top level of the note token parser: controller, datapath and stream ports.
//
// Takes a note token one ASCII character per word, tlast on the final
// character, and returns one result word per token. Characters are
// taken as they arrive while the block is not busy. After the final
// character the block decides the path; then, when the token has no
// grammar error and a nonzero digit value, it runs the bit-serial
// restoring divider, steps the dot loop once per dot until the dots run
// out or the dot increment reaches zero, and leaves the dot loop; last it
// loads the output register once it is free. Input stays stalled only
// during that end-of-token work; a finished word in the output register
// does not hold up the characters of the next token.
module music_note_token_parser_unit #(
  parameter int QUANT_UNITS = mntp_pkg::DEF_QUANT_UNITS,
  parameter int BASE_OCTAVE = mntp_pkg::DEF_BASE_OCTAVE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] pitch, [6:3] alteration, [11:7] octave,
                                  // [18:12] note_length, [23:19] zero
  output logic [2:0]  out_tuser   // [0] valid_res, [1] bad_accidental, [2] saturated
);

  mntp_pkg::cmd_t cmd;
  mntp_pkg::sts_t sts;
  mntp_pkg::res_t res;

  mntp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mntp_dp #(
    .QUANT_UNITS (QUANT_UNITS),
    .BASE_OCTAVE (BASE_OCTAVE)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .ch    (in_tdata),
    .cmd   (cmd),
    .sts   (sts),
    .res   (res)
  );

  // Pack the result word
  assign out_tdata = {5'd0, res.note_length, res.octave, res.alteration, res.pitch};
  assign out_tuser = {res.saturated, res.bad_accidental, res.valid_res};

endmodule
